/* hw/rtl/rc6fe_pkg.sv */
`default_nettype none

package rc6fe_pkg;

	localparam int CMD_BITS_DEF  = 8;
	localparam int CTRL_BITS_DEF = 8;
	localparam int FIELD_MAX     = 16;

	localparam int UNIT_W  = 10;
	localparam int TIME_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int SUM_W   = 16;
	localparam int CFG_W   = 12;

	localparam logic [UNIT_W-1:0] UNIT_RST       = 10'd444;
	localparam logic [TIME_W-1:0] LEAD_MARK_RST  = 12'd2666;
	localparam logic [TIME_W-1:0] LEAD_SPACE_RST = 12'd889;
	localparam logic [BYTE_W-1:0] CONTROL_RST    = 8'd0;

	// Start bit and the three mode bits, after merging, form six segments.
	localparam int HDR_SEGS = 6;
	localparam int HDR_W    = 3;

	typedef enum logic [1:0] {
		CFG_UNIT_TIME  = 2'd0,
		CFG_LEAD_MARK  = 2'd1,
		CFG_LEAD_SPACE = 2'd2,
		CFG_CONTROL    = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD_MARK,
		ST_LEAD_SPACE,
		ST_HDR,
		ST_TOGGLE,
		ST_TOG_SPACE,
		ST_BIT,
		ST_BIT_UNIT,
		ST_FINAL
	} state_t;

	typedef enum logic [3:0] {
		SEG_NONE,
		SEG_LEAD_MARK,
		SEG_LEAD_SPACE,
		SEG_HDR,
		SEG_TOG_LONG,
		SEG_TOG_MARK,
		SEG_TOG_SPACE,
		SEG_MERGE,
		SEG_PEND,
		SEG_UNIT,
		SEG_FINAL
	} seg_sel_t;

	typedef struct packed {
		logic     load;
		seg_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic hdr_last;
		logic bit_last;
		logic cur_bit;
		logic pend_mark;
		logic toggle;
	} dp_stat_t;

	// Header segment levels alternate starting with a mark; the second one spans two units.
	function automatic logic hdr_level(input logic [HDR_W-1:0] idx);
		hdr_level = ~idx[0];
	endfunction

	function automatic logic hdr_double(input logic [HDR_W-1:0] idx);
		hdr_double = (idx == HDR_W'(1));
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rc6fe_ctrl.sv */
`default_nettype none

module rc6fe_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  rc6fe_pkg::dp_stat_t stat,
	output rc6fe_pkg::dp_cmd_t  cmd
);

	rc6fe_pkg::state_t state_q;
	rc6fe_pkg::state_t state_d;
	logic              go;

	assign go = stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc6fe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rc6fe_pkg::ST_IDLE: begin
				if (in_valid) state_d = rc6fe_pkg::ST_LEAD_MARK;
			end
			rc6fe_pkg::ST_LEAD_MARK: begin
				if (go) state_d = rc6fe_pkg::ST_LEAD_SPACE;
			end
			rc6fe_pkg::ST_LEAD_SPACE: begin
				if (go) state_d = rc6fe_pkg::ST_HDR;
			end
			rc6fe_pkg::ST_HDR: begin
				if (go && stat.hdr_last) state_d = rc6fe_pkg::ST_TOGGLE;
			end
			rc6fe_pkg::ST_TOGGLE: begin
				if (go) state_d = stat.toggle ? rc6fe_pkg::ST_BIT : rc6fe_pkg::ST_TOG_SPACE;
			end
			rc6fe_pkg::ST_TOG_SPACE: begin
				if (go) state_d = rc6fe_pkg::ST_BIT;
			end
			rc6fe_pkg::ST_BIT: begin
				if (go) begin
					if (stat.cur_bit != stat.pend_mark) begin
						state_d = rc6fe_pkg::ST_BIT_UNIT;
					end else if (stat.bit_last) begin
						state_d = rc6fe_pkg::ST_FINAL;
					end
				end
			end
			rc6fe_pkg::ST_BIT_UNIT: begin
				if (go) state_d = stat.bit_last ? rc6fe_pkg::ST_FINAL : rc6fe_pkg::ST_BIT;
			end
			rc6fe_pkg::ST_FINAL: begin
				if (go) state_d = rc6fe_pkg::ST_IDLE;
			end
			default: begin
				state_d = rc6fe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.sel  = rc6fe_pkg::SEG_NONE;
		case (state_q)
			rc6fe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rc6fe_pkg::ST_LEAD_MARK: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_LEAD_MARK;
			end
			rc6fe_pkg::ST_LEAD_SPACE: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_LEAD_SPACE;
			end
			rc6fe_pkg::ST_HDR: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_HDR;
			end
			rc6fe_pkg::ST_TOGGLE: begin
				if (go) cmd.sel = stat.toggle ? rc6fe_pkg::SEG_TOG_LONG : rc6fe_pkg::SEG_TOG_MARK;
			end
			rc6fe_pkg::ST_TOG_SPACE: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_TOG_SPACE;
			end
			rc6fe_pkg::ST_BIT: begin
				if (go) begin
					cmd.sel = (stat.cur_bit == stat.pend_mark) ? rc6fe_pkg::SEG_MERGE
					                                           : rc6fe_pkg::SEG_PEND;
				end
			end
			rc6fe_pkg::ST_BIT_UNIT: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_UNIT;
			end
			rc6fe_pkg::ST_FINAL: begin
				if (go) cmd.sel = rc6fe_pkg::SEG_FINAL;
			end
			default: begin
				cmd.sel = rc6fe_pkg::SEG_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/rc6fe_datapath.sv */
`default_nettype none

module rc6fe_datapath #(
	parameter int CMD_BITS  = rc6fe_pkg::CMD_BITS_DEF,
	parameter int CTRL_BITS = rc6fe_pkg::CTRL_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire  [1:0]                          cfg_index,
	input  wire  [rc6fe_pkg::CFG_W-1:0]         cfg_data,
	input  wire  [rc6fe_pkg::BYTE_W-1:0]        in_command,
	input  wire                                 in_end_of_press,
	input  rc6fe_pkg::dp_cmd_t                  cmd,
	output rc6fe_pkg::dp_stat_t                 stat,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                out_level,
	output logic [rc6fe_pkg::TIME_W-1:0]        out_segment,
	output logic                                out_last,
	output logic [rc6fe_pkg::SUM_W-1:0]         out_period
);

	localparam int NBITS       = CTRL_BITS + CMD_BITS;
	localparam int BCNT_W      = $clog2(NBITS + 1);
	localparam int TW          = rc6fe_pkg::TIME_W;
	localparam int SW          = rc6fe_pkg::SUM_W;
	localparam int FIELD_MAX_W = rc6fe_pkg::FIELD_MAX;

	logic [rc6fe_pkg::UNIT_W-1:0] unit_q;
	logic [TW-1:0]                lead_mark_q;
	logic [TW-1:0]                lead_space_q;
	logic [rc6fe_pkg::BYTE_W-1:0] control_q;

	logic                         toggle_q;
	logic                         eop_q;
	logic [TW-1:0]                pend_time_q;
	logic                         pend_mark_q;
	logic [SW-1:0]                acc_q;
	logic [rc6fe_pkg::HDR_W-1:0]  hdr_q;
	logic [BCNT_W-1:0]            bcnt_q;
	logic [NBITS-1:0]             bits_q;

	logic                         out_valid_q;
	logic                         out_level_q;
	logic [TW-1:0]                out_segment_q;
	logic                         out_last_q;
	logic [SW-1:0]                out_period_q;

	logic [TW-1:0]                u12;
	logic [TW-1:0]                u2;
	logic [TW-1:0]                u3;
	logic [12:0]                  u6;
	logic [FIELD_MAX_W-1:0]       ctrl_ext;
	logic [FIELD_MAX_W-1:0]       cmd_ext;
	logic                         cur_bit;
	logic                         emit;
	logic                         seg_level;
	logic [TW-1:0]                seg_time;
	logic                         seg_last;
	logic [SW:0]                  sum_wide;
	logic [SW-1:0]                acc_next;
	logic                         bit_step;

	assign u12      = TW'(unit_q);
	assign u2       = {1'b0, unit_q, 1'b0};
	assign u3       = u2 + u12;
	assign u6       = 13'({unit_q, 2'b00}) + 13'({unit_q, 1'b0});
	assign ctrl_ext = FIELD_MAX_W'(control_q);
	assign cmd_ext  = FIELD_MAX_W'(in_command);
	assign cur_bit  = bits_q[NBITS-1];
	assign emit     = (cmd.sel != rc6fe_pkg::SEG_NONE);
	assign bit_step = (cmd.sel == rc6fe_pkg::SEG_MERGE) || (cmd.sel == rc6fe_pkg::SEG_UNIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q       <= rc6fe_pkg::UNIT_RST;
			lead_mark_q  <= rc6fe_pkg::LEAD_MARK_RST;
			lead_space_q <= rc6fe_pkg::LEAD_SPACE_RST;
			control_q    <= rc6fe_pkg::CONTROL_RST;
		end else if (cfg_valid) begin
			case (rc6fe_pkg::cfg_reg_t'(cfg_index))
				rc6fe_pkg::CFG_UNIT_TIME:  unit_q       <= cfg_data[rc6fe_pkg::UNIT_W-1:0];
				rc6fe_pkg::CFG_LEAD_MARK:  lead_mark_q  <= cfg_data[TW-1:0];
				rc6fe_pkg::CFG_LEAD_SPACE: lead_space_q <= cfg_data[TW-1:0];
				rc6fe_pkg::CFG_CONTROL:    control_q    <= cfg_data[rc6fe_pkg::BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		seg_level = 1'b0;
		seg_time  = '0;
		seg_last  = 1'b0;
		case (cmd.sel)
			rc6fe_pkg::SEG_LEAD_MARK: begin
				seg_level = 1'b1;
				seg_time  = lead_mark_q;
			end
			rc6fe_pkg::SEG_LEAD_SPACE: begin
				seg_level = 1'b0;
				seg_time  = lead_space_q;
			end
			rc6fe_pkg::SEG_HDR: begin
				seg_level = rc6fe_pkg::hdr_level(hdr_q);
				seg_time  = rc6fe_pkg::hdr_double(hdr_q) ? u2 : u12;
			end
			rc6fe_pkg::SEG_TOG_LONG: begin
				seg_level = 1'b1;
				seg_time  = u3;
			end
			rc6fe_pkg::SEG_TOG_MARK: begin
				seg_level = 1'b1;
				seg_time  = u12;
			end
			rc6fe_pkg::SEG_TOG_SPACE: begin
				seg_level = 1'b0;
				seg_time  = u2;
			end
			rc6fe_pkg::SEG_MERGE: begin
				seg_level = cur_bit;
				seg_time  = pend_time_q + u12;
			end
			rc6fe_pkg::SEG_PEND: begin
				seg_level = pend_mark_q;
				seg_time  = pend_time_q;
			end
			rc6fe_pkg::SEG_UNIT: begin
				seg_level = cur_bit;
				seg_time  = u12;
			end
			rc6fe_pkg::SEG_FINAL: begin
				seg_level = pend_mark_q;
				seg_time  = pend_time_q;
				seg_last  = 1'b1;
			end
			default: begin
				seg_level = 1'b0;
			end
		endcase
	end

	// The accumulator starts at the six-unit gap, so the saturated sum is the period.
	assign sum_wide = {1'b0, acc_q} + (SW + 1)'(seg_time);
	assign acc_next = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q    <= 1'b0;
			eop_q       <= 1'b0;
			pend_time_q <= '0;
			pend_mark_q <= 1'b0;
			acc_q       <= '0;
			hdr_q       <= '0;
			bcnt_q      <= '0;
			bits_q      <= '0;
		end else begin
			if (cmd.load) begin
				eop_q  <= in_end_of_press;
				acc_q  <= SW'(u6);
				hdr_q  <= '0;
				bcnt_q <= BCNT_W'(NBITS);
				bits_q <= {ctrl_ext[CTRL_BITS-1:0], cmd_ext[CMD_BITS-1:0]};
			end else if (emit) begin
				acc_q <= acc_next;
			end
			if (cmd.sel == rc6fe_pkg::SEG_HDR) begin
				hdr_q <= hdr_q + 1'b1;
			end
			if (bit_step) begin
				bcnt_q      <= bcnt_q - 1'b1;
				bits_q      <= bits_q << 1;
				pend_time_q <= u12;
				pend_mark_q <= ~cur_bit;
			end
			if (cmd.sel == rc6fe_pkg::SEG_TOG_LONG) begin
				pend_time_q <= u2;
				pend_mark_q <= 1'b0;
			end
			if (cmd.sel == rc6fe_pkg::SEG_TOG_SPACE) begin
				pend_time_q <= u2;
				pend_mark_q <= 1'b1;
			end
			if (cmd.sel == rc6fe_pkg::SEG_FINAL) begin
				pend_time_q <= '0;
				pend_mark_q <= 1'b0;
				if (eop_q) toggle_q <= ~toggle_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_level_q   <= seg_level;
			out_segment_q <= seg_time;
			out_last_q    <= seg_last;
			out_period_q  <= seg_last ? acc_next : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_level   = out_level_q;
	assign out_segment = out_segment_q;
	assign out_last    = out_last_q;
	assign out_period  = out_period_q;

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.hdr_last  = (hdr_q == rc6fe_pkg::HDR_W'(rc6fe_pkg::HDR_SEGS - 1));
	assign stat.bit_last  = (bcnt_q == BCNT_W'(1));
	assign stat.cur_bit   = cur_bit;
	assign stat.pend_mark = pend_mark_q;
	assign stat.toggle    = toggle_q;

endmodule

`default_nettype wire

/* hw/rtl/rc6_frame_encoder_unit.sv */
`default_nettype none

// RC6 mode 0 frame encoder. Each input transaction requests one frame and
// yields its mark and space segments in order, one output transaction per
// segment, the final one flagged by m_tlast and carrying the frame period.
// The block works on one frame at a time: s_tready is high only while it is
// idle. After a request is taken, the sequencer emits one segment per cycle
// into the output register while the output is not stalled, so a frame has
// 2 + 6 + (1 or 2) + (N to 2N) + 1 segments with N = CTRL_BITS + CMD_BITS
// (at most 43 with the defaults). Configuration writes are always ready and
// belong between frames.
module rc6_frame_encoder_unit #(
	parameter int CMD_BITS  = rc6fe_pkg::CMD_BITS_DEF,
	parameter int CTRL_BITS = rc6fe_pkg::CTRL_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,     // command_code
	input  wire         s_tlast,     // end_of_press
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,     // segment_us, frame_period_us, zero fill
	output logic        m_tuser,     // level
	output logic        m_tlast,     // last
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [11:0] cfg_data
);

	rc6fe_pkg::dp_cmd_t                 cmd;
	rc6fe_pkg::dp_stat_t                stat;
	logic [rc6fe_pkg::TIME_W-1:0]       segment;
	logic [rc6fe_pkg::SUM_W-1:0]        period;

	assign cfg_ready = 1'b1;

	rc6fe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rc6fe_datapath #(
		.CMD_BITS  (CMD_BITS),
		.CTRL_BITS (CTRL_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_command      (s_tdata),
		.in_end_of_press (s_tlast),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_level       (m_tuser),
		.out_segment     (segment),
		.out_last        (m_tlast),
		.out_period      (period)
	);

	assign m_tdata = {4'b0000, period, segment};

	a_period_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[27:12] == 16'd0)
		else $error("frame period present on a segment that is not the last");

	a_one_frame_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while a frame is in progress");

	a_period_covers_segment: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[27:12] >= 16'(m_tdata[11:0]))
		else $error("frame period shorter than its final segment");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;

	localparam int CMD_BITS    = rc6fe_pkg::CMD_BITS_DEF;
	localparam int CTRL_BITS   = rc6fe_pkg::CTRL_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic                         level;
		logic [rc6fe_pkg::TIME_W-1:0] dur;
		logic                         fin;
		logic [rc6fe_pkg::SUM_W-1:0]  period;
	} segment_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	segment_t                     expected_segments[$];
	logic [rc6fe_pkg::UNIT_W-1:0] unit_us    = rc6fe_pkg::UNIT_RST;
	logic [rc6fe_pkg::TIME_W-1:0] lead_mark  = rc6fe_pkg::LEAD_MARK_RST;
	logic [rc6fe_pkg::TIME_W-1:0] lead_space = rc6fe_pkg::LEAD_SPACE_RST;
	logic [rc6fe_pkg::BYTE_W-1:0] ctrl_byte  = rc6fe_pkg::CONTROL_RST;
	logic                         toggle     = 1'b0;
	int unsigned                  frame_sum;
	logic [rc6fe_pkg::TIME_W-1:0] held_dur;
	logic                         held_mark;
	logic                         held_space;

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int quiet_cycles = 0;

	rc6_frame_encoder_unit #(
		.CMD_BITS (CMD_BITS),
		.CTRL_BITS(CTRL_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void add_segment(input logic lvl, input int unsigned dur, input logic fin);
		segment_t    seg;
		int unsigned p;
		seg.level = lvl;
		seg.dur = dur[rc6fe_pkg::TIME_W-1:0];
		seg.fin = fin;
		seg.period = '0;
		frame_sum += 32'(seg.dur);
		if (frame_sum > 65535) frame_sum = 65535;
		if (fin) begin
			p = frame_sum + 6 * 32'(unit_us);
			if (p > 65535) p = 65535;
			seg.period = p[rc6fe_pkg::SUM_W-1:0];
		end
		expected_segments.push_back(seg);
	endfunction

	// A half that continues the held level merges with it; otherwise the held half goes out.
	function automatic void encode_bit(input logic b);
		int unsigned u;
		u = 32'(unit_us);
		if (b) begin
			if (held_mark) begin
				add_segment(1'b1, 32'(held_dur) + u, 1'b0);
			end else begin
				if (held_space) add_segment(1'b0, 32'(held_dur), 1'b0);
				add_segment(1'b1, u, 1'b0);
			end
			held_space = 1'b1;
			held_mark = 1'b0;
		end else begin
			if (held_space) begin
				add_segment(1'b0, 32'(held_dur) + u, 1'b0);
			end else begin
				if (held_mark) add_segment(1'b1, 32'(held_dur), 1'b0);
				add_segment(1'b0, u, 1'b0);
			end
			held_mark = 1'b1;
			held_space = 1'b0;
		end
		held_dur = u[rc6fe_pkg::TIME_W-1:0];
	endfunction

	function automatic void encode_frame(input logic [7:0] cmd, input logic end_press);
		int unsigned u;
		int unsigned twice;
		u = 32'(unit_us);
		twice = 2 * u;
		frame_sum = 0;
		add_segment(1'b1, 32'(lead_mark), 1'b0);
		add_segment(1'b0, 32'(lead_space), 1'b0);
		add_segment(1'b1, u, 1'b0);
		add_segment(1'b0, twice, 1'b0);
		add_segment(1'b1, u, 1'b0);
		add_segment(1'b0, u, 1'b0);
		add_segment(1'b1, u, 1'b0);
		add_segment(1'b0, u, 1'b0);
		if (toggle) begin
			add_segment(1'b1, 3 * u, 1'b0);
			held_mark = 1'b0;
			held_space = 1'b1;
		end else begin
			add_segment(1'b1, u, 1'b0);
			add_segment(1'b0, twice, 1'b0);
			held_mark = 1'b1;
			held_space = 1'b0;
		end
		held_dur = twice[rc6fe_pkg::TIME_W-1:0];
		for (int i = CTRL_BITS - 1; i >= 0; i--)
			encode_bit(i < 8 ? ctrl_byte[i] : 1'b0);
		for (int i = CMD_BITS - 1; i >= 0; i--)
			encode_bit(i < 8 ? cmd[i] : 1'b0);
		add_segment(held_mark, 32'(held_dur), 1'b1);
		held_mark = 1'b0;
		held_space = 1'b0;
		if (end_press) toggle = ~toggle;
	endfunction

	function automatic void check_segment();
		segment_t seg;
		if (expected_segments.size() == 0) begin
			$error("unexpected segment: level %0d, segment_us %0d", m_tuser, m_tdata[11:0]);
			mismatch_count++;
		end else begin
			seg = expected_segments.pop_front();
			if (m_tuser !== seg.level) begin
				$error("level: expected %0d, actual %0d", seg.level, m_tuser);
				mismatch_count++;
			end
			if (m_tdata[11:0] !== seg.dur) begin
				$error("segment_us: expected %0d, actual %0d", seg.dur, m_tdata[11:0]);
				mismatch_count++;
			end
			if (m_tlast !== seg.fin) begin
				$error("last: expected %0d, actual %0d", seg.fin, m_tlast);
				mismatch_count++;
			end
			if (m_tdata[27:12] !== seg.period) begin
				$error("frame_period_us: expected %0d, actual %0d", seg.period, m_tdata[27:12]);
				mismatch_count++;
			end
		end
	endfunction

	// The output side checks each transaction and then picks its ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_segment();
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("rc6_frame_encoder_unit: mismatch");
			$finish;
		end
	end

	task automatic send_frame(input logic [7:0] cmd, input logic end_press);
		if (send_idle_pct > 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= cmd;
		s_tlast <= end_press;
		do @(posedge clk); while (!s_tready);
		encode_frame(cmd, end_press);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_segments.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input rc6fe_pkg::cfg_reg_t idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rc6fe_pkg::CFG_UNIT_TIME:  unit_us = value[rc6fe_pkg::UNIT_W-1:0];
			rc6fe_pkg::CFG_LEAD_MARK:  lead_mark = value;
			rc6fe_pkg::CFG_LEAD_SPACE: lead_space = value;
			rc6fe_pkg::CFG_CONTROL:    ctrl_byte = value[rc6fe_pkg::BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [9:0] unit, input logic [11:0] mark,
			input logic [11:0] space, input logic [7:0] ctrl);
		write_reg(rc6fe_pkg::CFG_UNIT_TIME, {2'b00, unit});
		write_reg(rc6fe_pkg::CFG_LEAD_MARK, mark);
		write_reg(rc6fe_pkg::CFG_LEAD_SPACE, space);
		write_reg(rc6fe_pkg::CFG_CONTROL, {4'h0, ctrl});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_frame(8'h00, 1'b0);
		send_frame(8'hFF, 1'b0);
		send_frame(8'h55, 1'b1);
		send_frame(8'hAA, 1'b0);
		send_frame(8'h80, 1'b0);
		send_frame(8'h01, 1'b1);
		drain();
	endtask

	task automatic test_config_extremes();
		configure(10'd1023, 12'd4095, 12'd4095, 8'hFF);
		send_frame(8'hFF, 1'b1);
		send_frame(8'h00, 1'b0);
		drain();
		configure(10'd1, 12'd1, 12'd1, 8'h00);
		send_frame(8'h00, 1'b1);
		send_frame(8'hFF, 1'b0);
		drain();
	endtask

	task automatic test_zero_durations();
		configure(10'd0, 12'd0, 12'd0, 8'hA5);
		send_frame(8'h3C, 1'b1);
		send_frame(8'hC3, 1'b0);
		drain();
	endtask

	task automatic test_output_hold();
		configure(10'd444, 12'd2666, 12'd889, 8'h5A);
		hold_req = 1'b1;
		send_frame(8'h12, 1'b0);
		send_frame(8'h34, 1'b1);
		send_frame(8'h56, 1'b0);
		drain();
	endtask

	task automatic test_sender_pause();
		recv_stall_pct = 50;
		send_frame(8'h9E, 1'b0);
		drain();
		send_frame(8'h61, 1'b1);
		drain();
		send_frame(8'hE7, 1'b0);
		drain();
		recv_stall_pct = 0;
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < 2; s++) begin
			configure(10'($urandom_range(1, 1023)), 12'($urandom_range(1, 4095)),
				12'($urandom_range(1, 4095)), 8'($urandom_range(255)));
			for (int i = 0; i < 24; i++)
				send_frame(8'($urandom_range(255)), $urandom_range(99) < 30);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_zero_durations();
		test_output_hold();
		test_sender_pause();
		test_random_traffic(0, 0);
		test_random_traffic(84, 0);
		test_random_traffic(0, 84);
		test_random_traffic(19, 19);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_segments.size() == 0)
			$display("rc6_frame_encoder_unit: match");
		else
			$display("rc6_frame_encoder_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

/* rc6_frame_encoder_unit.f */
hw/rtl/rc6fe_pkg.sv
hw/rtl/rc6fe_ctrl.sv
hw/rtl/rc6fe_datapath.sv
hw/rtl/rc6_frame_encoder_unit.sv
tb/tb.sv
